// ===== hw/rtl/alu32_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu32_pkg
// Shared action codes, widths and the word carried along the cell chain.
// ----------------------------------------------------------------------------
package alu32_pkg;

    localparam int unsigned DataW  = 32;
    localparam int unsigned NCells = DataW;

    typedef enum logic [4:0] {
        ACT_AND    = 5'd0,
        ACT_OR     = 5'd1,
        ACT_XOR    = 5'd2,
        ACT_BITCLR = 5'd3,
        ACT_ADD    = 5'd4,
        ACT_ADDC   = 5'd5,
        ACT_SUB    = 5'd6,
        ACT_SUBB   = 5'd7,
        ACT_RSB    = 5'd8,
        ACT_RSBB   = 5'd9,
        ACT_LLS    = 5'd10,
        ACT_RLS    = 5'd11,
        ACT_ARS    = 5'd12,
        ACT_ROTL   = 5'd13,
        ACT_ROTR   = 5'd14,
        ACT_MUL    = 5'd15,
        ACT_SMUL   = 5'd16,
        ACT_DIV    = 5'd17,
        ACT_SDIV   = 5'd18
    } action_t;

    // One word in flight. For a divide, quo holds the dividend bits still to
    // shift in plus the quotient bits made so far; otherwise it is the result.
    typedef struct packed {
        logic             valid;
        logic             is_div;
        logic             neg_q;
        logic             neg_r;
        logic [DataW-1:0] quo;
        logic [DataW-1:0] rem;
        logic [DataW-1:0] dvs;
        logic [DataW-1:0] hi;
        logic             hv;
        logic             wr;
        logic             cy;
        logic             ov;
        logic             dz;
    } stage_t;

endpackage

// ===== hw/rtl/alu32_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu32_prep
// Front logic: logic, add/sub, shift, rotate and multiply results, and the
// divide setup (magnitudes and result signs) for the cell chain.
// ----------------------------------------------------------------------------
module alu32_prep (
    input  logic [4:0]                  action,
    input  logic [alu32_pkg::DataW-1:0] operand_a,
    input  logic [alu32_pkg::DataW-1:0] operand_b,
    input  logic                        carry_in,
    input  logic                        overflow_in,
    input  logic                        in_valid,
    output alu32_pkg::stage_t           stage_out
);
    localparam int unsigned W = alu32_pkg::DataW;

    alu32_pkg::action_t    act;
    logic [W:0]            sum_w;
    logic [W+1:0]          diff_ab;
    logic [W+1:0]          diff_ba;
    logic                  c_sel;
    logic                  shift_big;
    logic [5:0]            sh_amt;
    logic [W:0]            shl_w;
    logic [W:0]            shr_w;
    logic [W:0]            sar_w;
    logic [2*W-1:0]        rotl_w;
    logic [2*W-1:0]        rotr_w;
    logic                  sgn_mul;
    logic [W:0]            ma;
    logic [W:0]            mb;
    logic signed [2*W+1:0] prod;
    logic                  a_s;
    logic                  b_s;
    logic                  sdiv;
    logic [W-1:0]          ua;
    logic [W-1:0]          ub;

    always_comb begin
        act       = alu32_pkg::action_t'(action);
        a_s       = operand_a[W-1];
        b_s       = operand_b[W-1];
        c_sel     = (act == alu32_pkg::ACT_ADDC || act == alu32_pkg::ACT_SUBB ||
                     act == alu32_pkg::ACT_RSBB) ? carry_in : 1'b0;
        sum_w     = {1'b0, operand_a} + {1'b0, operand_b} + {{W{1'b0}}, c_sel};
        diff_ab   = {2'b00, operand_a} - {2'b00, operand_b} - {{(W+1){1'b0}}, c_sel};
        diff_ba   = {2'b00, operand_b} - {2'b00, operand_a} - {{(W+1){1'b0}}, c_sel};
        shift_big = (|operand_b[W-1:6]) || (operand_b[5:0] > 6'd32);
        sh_amt    = shift_big ? 6'd33 : operand_b[5:0];
        shl_w     = {1'b0, operand_a} << sh_amt;
        shr_w     = {operand_a, 1'b0} >> sh_amt;
        sar_w     = $unsigned($signed({operand_a, 1'b0}) >>> sh_amt);
        rotl_w    = {operand_a, operand_a} << operand_b[4:0];
        rotr_w    = {operand_a, operand_a} >> operand_b[4:0];
        sgn_mul   = (act == alu32_pkg::ACT_SMUL);
        ma        = {sgn_mul & a_s, operand_a};
        mb        = {sgn_mul & b_s, operand_b};
        prod      = $signed(ma) * $signed(mb);
        sdiv      = (act == alu32_pkg::ACT_SDIV);
        ua        = (sdiv && a_s) ? (~operand_a + 1'b1) : operand_a;
        ub        = (sdiv && b_s) ? (~operand_b + 1'b1) : operand_b;

        stage_out        = '0;
        stage_out.valid  = in_valid;
        stage_out.wr     = 1'b1;
        stage_out.dvs    = ub;

        unique case (act)
            alu32_pkg::ACT_AND:    stage_out.quo = operand_a & operand_b;
            alu32_pkg::ACT_OR:     stage_out.quo = operand_a | operand_b;
            alu32_pkg::ACT_XOR:    stage_out.quo = operand_a ^ operand_b;
            alu32_pkg::ACT_BITCLR: stage_out.quo = operand_a & ~operand_b;
            alu32_pkg::ACT_ADD, alu32_pkg::ACT_ADDC: begin
                stage_out.quo = sum_w[W-1:0];
                stage_out.cy  = sum_w[W];
                stage_out.ov  = (a_s == b_s) ? (b_s != sum_w[W-1]) : overflow_in;
            end
            alu32_pkg::ACT_SUB, alu32_pkg::ACT_SUBB: begin
                stage_out.quo = diff_ab[W-1:0];
                stage_out.cy  = diff_ab[W+1];
                stage_out.ov  = (a_s != b_s) ? (b_s == diff_ab[W-1]) : overflow_in;
            end
            alu32_pkg::ACT_RSB, alu32_pkg::ACT_RSBB: begin
                stage_out.quo = diff_ba[W-1:0];
                stage_out.cy  = diff_ba[W+1];
                stage_out.ov  = (a_s != b_s) ? (a_s == diff_ba[W-1]) : overflow_in;
            end
            alu32_pkg::ACT_LLS: begin
                stage_out.quo = shl_w[W-1:0];
                stage_out.cy  = shl_w[W];
            end
            alu32_pkg::ACT_RLS: begin
                stage_out.quo = shr_w[W:1];
                stage_out.cy  = shr_w[0];
            end
            alu32_pkg::ACT_ARS: begin
                stage_out.quo = sar_w[W:1];
                stage_out.cy  = sar_w[0];
            end
            alu32_pkg::ACT_ROTL: stage_out.quo = rotl_w[2*W-1:W];
            alu32_pkg::ACT_ROTR: stage_out.quo = rotr_w[W-1:0];
            alu32_pkg::ACT_MUL, alu32_pkg::ACT_SMUL: begin
                stage_out.quo = prod[W-1:0];
                stage_out.hi  = prod[2*W-1:W];
                stage_out.hv  = 1'b1;
            end
            alu32_pkg::ACT_DIV, alu32_pkg::ACT_SDIV: begin
                if (operand_b == '0) begin
                    stage_out.wr = 1'b0;
                    stage_out.dz = 1'b1;
                end else begin
                    stage_out.is_div = 1'b1;
                    stage_out.quo    = ua;
                    stage_out.hv     = 1'b1;
                    stage_out.neg_q  = sdiv & (a_s ^ b_s);
                    stage_out.neg_r  = sdiv & a_s;
                end
            end
            default: begin
                stage_out.wr = 1'b0;
                stage_out.cy = carry_in;
                stage_out.ov = overflow_in;
            end
        endcase
    end

endmodule

// ===== hw/rtl/alu32_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu32_div_cell
// One link of the chain: register the word and, for a divide, make one
// restoring quotient bit. Other words pass unchanged.
// ----------------------------------------------------------------------------
module alu32_div_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  alu32_pkg::stage_t stage_in,
    output alu32_pkg::stage_t stage_out
);
    localparam int unsigned W = alu32_pkg::DataW;

    alu32_pkg::stage_t stage_reg;
    alu32_pkg::stage_t stage_next;
    logic [W:0]        part;
    logic [W:0]        trial;

    always_comb begin
        stage_next = stage_in;
        part       = {stage_in.rem, stage_in.quo[W-1]};
        trial      = part - {1'b0, stage_in.dvs};
        if (stage_in.is_div) begin
            if (!trial[W]) begin
                stage_next.rem = trial[W-1:0];
            end else begin
                stage_next.rem = part[W-1:0];
            end
            stage_next.quo = {stage_in.quo[W-2:0], ~trial[W]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (advance) begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

// ===== hw/rtl/alu32_with_flags_mul_div_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu32_with_flags_mul_div_top
// 32-bit execute unit with carry/overflow flags, multiply and divide.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | action, operands, carry, overflow
//  m_      | out       | m_valid / m_ready  | result words and flags
//
//  One word enters per cycle unless the output stalls; words leave in order
//  after passing the chain of 32 divide cells (one quotient bit each) and the
//  output register. The multiply is done before the first cell.
//  Reset clears only the valid bits of the chain and output register.
//  A stalled output word freezes the whole chain, empty slots included;
//  bubbles are not squeezed out.
// ----------------------------------------------------------------------------
module alu32_with_flags_mul_div_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [4:0]                  s_action,
    input  logic [alu32_pkg::DataW-1:0] s_operand_a,
    input  logic [alu32_pkg::DataW-1:0] s_operand_b,
    input  logic                        s_carry_in,
    input  logic                        s_overflow_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [alu32_pkg::DataW-1:0] m_result_low,
    output logic [alu32_pkg::DataW-1:0] m_result_high,
    output logic                        m_high_valid,
    output logic                        m_write_result,
    output logic                        m_carry_out,
    output logic                        m_overflow_out,
    output logic                        m_divide_by_zero
);
    localparam int unsigned W = alu32_pkg::DataW;
    localparam int unsigned N = alu32_pkg::NCells;

    alu32_pkg::stage_t chain [N+1];
    logic              advance;
    logic              out_valid_reg;
    logic [W-1:0]      lo_reg;
    logic [W-1:0]      lo_next;
    logic [W-1:0]      hi_reg;
    logic [W-1:0]      hi_next;
    logic [4:0]        flags_reg;

    // advance everything whenever the output slot is free or being drained
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = advance;

    alu32_prep u_prep (
        .action      (s_action),
        .operand_a   (s_operand_a),
        .operand_b   (s_operand_b),
        .carry_in    (s_carry_in),
        .overflow_in (s_overflow_in),
        .in_valid    (s_valid),
        .stage_out   (chain[0])
    );

    for (genvar i = 0; i < N; i++) begin : g_cell
        alu32_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .stage_in  (chain[i]),
            .stage_out (chain[i+1])
        );
    end

    // apply the signs of a signed divide on the way out
    always_comb begin
        lo_next = chain[N].quo;
        hi_next = chain[N].hi;
        if (chain[N].is_div) begin
            lo_next = chain[N].neg_q ? (~chain[N].quo + 1'b1) : chain[N].quo;
            hi_next = chain[N].neg_r ? (~chain[N].rem + 1'b1) : chain[N].rem;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= chain[N].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            flags_reg <= {chain[N].hv, chain[N].wr, chain[N].cy, chain[N].ov, chain[N].dz};
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_result_low     = lo_reg;
    assign m_result_high    = hi_reg;
    assign m_high_valid     = flags_reg[4];
    assign m_write_result   = flags_reg[3];
    assign m_carry_out      = flags_reg[2];
    assign m_overflow_out   = flags_reg[1];
    assign m_divide_by_zero = flags_reg[0];

endmodule

// ===== hw/rtl/alu32_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu32_checker
// Port-level checks on the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
module alu32_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [alu32_pkg::DataW-1:0] m_result_low,
    input logic                        m_high_valid,
    input logic                        m_write_result,
    input logic                        m_divide_by_zero
);

    a_hold_valid : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result word dropped");

    a_hold_data : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_result_low)) else $error("stalled word changed");

    a_dz_no_write : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divide_by_zero |-> !m_write_result && !m_high_valid)
        else $error("divide by zero wrote a result");

    a_high_write : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_high_valid |-> m_write_result)
        else $error("high word without low word");

    a_ready_empty : assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready) else $error("input stalled with empty output");

endmodule

bind alu32_with_flags_mul_div_top alu32_checker u_alu32_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_result_low     (m_result_low),
    .m_high_valid     (m_high_valid),
    .m_write_result   (m_write_result),
    .m_divide_by_zero (m_divide_by_zero)
);
